// ----- design/rtef_pkg.sv -----
// ----------------------------------------------------------------------------
// rtef_pkg
// Shared types and constants for the ray/tetrahedron exit-face finder.
// ----------------------------------------------------------------------------
package rtef_pkg;

  localparam int CW = 32;
  localparam int QB = 30;
  localparam logic signed [CW-1:0] DIST_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] DIST_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam int DW = 64;
  localparam int QW = 66;
  localparam logic [6:0] DIV_STEPS = 7'(QW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COS,
    ST_HGT,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ----- design/rtef_mac.sv -----
// ----------------------------------------------------------------------------
// rtef_mac
// Shared multiply-accumulate unit: one 32x32 product per cycle into a wide sum.
// ----------------------------------------------------------------------------
module rtef_mac (
  input  logic                          clk,
  input  logic                          clr,
  input  logic                          en,
  input  logic signed [rtef_pkg::CW-1:0] a,
  input  logic signed [rtef_pkg::CW-1:0] b,
  output logic signed [67:0]            acc
);
  import rtef_pkg::*;

  logic signed [63:0] prod;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc + 68'(prod);
    end
  end

endmodule

// ----- design/rtef_div.sv -----
// ----------------------------------------------------------------------------
// rtef_div
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module rtef_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rtef_pkg::QW-1:0] num,
  input  logic [rtef_pkg::DW-1:0] den,
  output logic [rtef_pkg::QW-1:0] quo,
  output rtef_pkg::div_ctl_t     ctl
);
  import rtef_pkg::*;

  logic [QW-1:0] n;
  logic [DW:0]   r;
  logic [6:0]    cnt;
  logic [DW:0]   trial;
  logic          done;

  assign trial = {r[DW-1:0], n[QW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DIV_STEPS;
      end else if (cnt != 0) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n <= num;
      r <= '0;
    end else if (cnt != 0) begin
      if (!trial[DW]) begin
        r <= trial;
        n <= {n[QW-2:0], 1'b1};
      end else begin
        r <= {r[DW-1:0], n[QW-1]};
        n <= {n[QW-2:0], 1'b0};
      end
    end
  end

  assign quo = n;
  assign ctl = {start, cnt != 0, done};

endmodule

// ----- design/ray_tetrahedron_exit_face.sv -----
// ----------------------------------------------------------------------------
// ray_tetrahedron_exit_face
// Iterative exit-face finder: shared MAC for dot products, serial divider.
// ----------------------------------------------------------------------------
// channel | direction | fields
// in      | input     | pos, dir, normal, plane_offset, face_number, last_face
// out     | output    | hit, exit_face, distance, exit_cosine
// Each word runs the cosine, then the height on the shared multiplier, then the
// one-bit-per-cycle divider, then update and idle. Faces with non-negative
// cosine skip height and divide and go straight to update.
// in_stall is high while a word is in work; a last word holds in update while
// the previous result waits on out_stall.
// rst is synchronous and clears the running minimum.
module ray_tetrahedron_exit_face (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  input  logic signed [31:0] plane_offset,
  input  logic [1:0]         face_number,
  input  logic               last_face,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [1:0]         exit_face,
  output logic signed [31:0] distance,
  output logic signed [30:0] exit_cosine
);
  import rtef_pkg::*;

  state_t state, state_next;
  logic [2:0] step;
  logic signed [31:0] px, py, pz, dx, dy, dz, nx, ny, nz, off;
  logic [1:0] face;
  logic last;
  logic signed [31:0] ma, mb;
  logic mclr, men;
  logic signed [67:0] acc;
  logic signed [37:0] cosv;
  logic signed [39:0] hgt;
  logic signed [31:0] best_distance;
  logic [1:0] best_face;
  logic signed [31:0] best_cosine;
  logic found_any;
  logic div_start;
  logic [QW-1:0] div_num, quo;
  logic [DW-1:0] div_den;
  div_ctl_t dctl;
  logic neg;
  logic [QW:0] mag;
  logic signed [31:0] s;
  logic accept;
  logic upd_go;

  assign accept = in_valid && !in_stall;
  assign in_stall = state != ST_IDLE;
  assign upd_go = state == ST_UPD && !(last && out_valid && out_stall);

  rtef_mac u_mac (.clk(clk), .clr(mclr), .en(men), .a(ma), .b(mb), .acc(acc));

  always_comb begin
    ma = nx; mb = dx;
    case (step)
      3'd1: begin ma = ny; mb = (state == ST_COS) ? dy : py; end
      3'd2: begin ma = nz; mb = (state == ST_COS) ? dz : pz; end
      default: begin ma = nx; mb = (state == ST_COS) ? dx : px; end
    endcase
  end

  always_comb begin
    mclr = accept || (state == ST_COS && step == 3'd4);
    men = (state == ST_COS || state == ST_HGT) && step >= 3'd1 && step <= 3'd3;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_COS;
      ST_COS: if (step == 3'd4) state_next = acc < 0 ? ST_HGT : ST_UPD;
      ST_HGT: if (step == 3'd5) state_next = ST_DIV;
      ST_DIV: if (dctl.done) state_next = ST_UPD;
      ST_UPD: if (upd_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= (state_next != state) ? 3'd0 : step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= pos_x; py <= pos_y; pz <= pos_z;
      dx <= dir_x; dy <= dir_y; dz <= dir_z;
      nx <= normal_x; ny <= normal_y; nz <= normal_z;
      off <= plane_offset; face <= face_number; last <= last_face;
    end
    if (state == ST_COS && step == 3'd4) cosv <= 38'(acc >>> QB);
    if (state == ST_HGT && step == 3'd4) hgt <= 40'(acc >>> QB) + 40'(off);
  end

  assign neg = hgt > 0;
  assign div_start = state == ST_HGT && step == 3'd5;

  always_comb begin
    logic [39:0] hm;
    hm = neg ? 40'(hgt) : 40'(-hgt);
    div_num = QW'({hm, 30'd0});
    div_den = DW'(-cosv);
  end

  rtef_div u_div (.clk(clk), .rst(rst), .start(div_start), .num(div_num),
                  .den(div_den), .quo(quo), .ctl(dctl));

  always_comb begin
    mag = {1'b0, quo};
    s = DIST_MAX;
    if (!neg) begin
      if (mag > (QW+1)'(DIST_MAX)) s = DIST_MAX;
      else s = 32'(mag);
    end else begin
      if (mag >= (QW+1)'(33'h080000000)) s = DIST_MIN;
      else s = 32'(-mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= DIST_MAX; best_face <= '0;
      best_cosine <= '0; found_any <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(upd_go && last)) out_valid <= 1'b0;
      if (upd_go) begin
        logic take;
        logic signed [31:0] bd;
        logic [1:0] bf;
        logic signed [31:0] bc;
        logic fa;
        take = cosv < 0 && (!found_any || s < best_distance);
        bd = take ? s : best_distance;
        bf = take ? face : best_face;
        bc = take ? (cosv < -38'sd1073741824 ? -32'sd1073741824 : 32'(cosv))
                  : best_cosine;
        fa = found_any || take;
        if (last) begin
          out_valid <= 1'b1;
          hit <= fa;
          exit_face <= fa ? bf : 2'd0;
          distance <= fa ? bd : DIST_MAX;
          exit_cosine <= fa ? 31'(bc) : 31'd0;
          best_distance <= DIST_MAX; best_face <= '0;
          best_cosine <= '0; found_any <= 1'b0;
        end else begin
          best_distance <= bd; best_face <= bf;
          best_cosine <= bc; found_any <= fa;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    dctl.done |-> state == ST_DIV) else $error("divider done outside divide");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("accept while busy");
  a_cos_clamp: assert property (@(posedge clk) disable iff (rst)
    found_any |-> best_cosine < 0 && best_cosine >= -32'sd1073741824)
    else $error("stored cosine out of range");
`endif

endmodule

// ----- tb/tb_ray_tetrahedron_exit_face.sv -----
// ----------------------------------------------------------------------------
// tb_ray_tetrahedron_exit_face
// Self-checking bench for the exit-face finder. Sends face words grouped into
// rays, predicts hit, face, distance and cosine in the bench, and compares each
// output word in order with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_ray_tetrahedron_exit_face;
  import rtef_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [1:0]        face;
    logic signed [31:0] dst;
    logic signed [30:0] cosine;
  } exit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [31:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [31:0] plane_offset = '0;
  logic [1:0] face_number = '0;
  logic last_face = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [1:0] exit_face;
  logic signed [31:0] distance;
  logic signed [30:0] exit_cosine;

  exit_t exits_due[$];
  int errors = 0;
  int words_sent = 0;
  int rays_checked = 0;
  int hits_seen = 0;
  int idle_pct = 20;
  logic signed [63:0] min_dist;
  logic [1:0] min_face;
  logic signed [63:0] min_cos;
  logic any_hit;

  always #2 clk = ~clk;

  ray_tetrahedron_exit_face u_top (.*);

  function automatic logic signed [63:0] dot_floor(
    input logic signed [31:0] a0, a1, a2, b0, b1, b2);
    logic signed [95:0] acc;
    begin
      acc = 96'(a0) * 96'(b0) + 96'(a1) * 96'(b1) + 96'(a2) * 96'(b2);
      return 64'(acc >>> QB);
    end
  endfunction

  function automatic logic signed [63:0] face_dist(
    input logic signed [63:0] height, input logic signed [63:0] cosv);
    logic signed [127:0] q;
    begin
      q = (-128'(height) <<< QB) / (-128'(cosv));
      if (q > 128'(DIST_MAX)) q = 128'(DIST_MAX);
      if (q < 128'(DIST_MIN)) q = 128'(DIST_MIN);
      return 64'(q);
    end
  endfunction

  task automatic clear_min();
    min_dist = 64'(DIST_MAX);
    min_face = '0;
    min_cos = '0;
    any_hit = 1'b0;
  endtask

  task automatic predict_face();
    logic signed [63:0] cosv, h, s;
    exit_t e;
    begin
      cosv = dot_floor(normal_x, normal_y, normal_z, dir_x, dir_y, dir_z);
      if (cosv < 0) begin
        h = dot_floor(normal_x, normal_y, normal_z, pos_x, pos_y, pos_z)
            + 64'(plane_offset);
        s = face_dist(h, cosv);
        if (!any_hit || s < min_dist) begin
          min_dist = s;
          min_face = face_number;
          min_cos = (cosv < -64'sd1073741824) ? -64'sd1073741824 : cosv;
          any_hit = 1'b1;
        end
      end
      if (last_face) begin
        e.hit = any_hit;
        e.face = any_hit ? min_face : 2'd0;
        e.dst = any_hit ? 32'(min_dist) : DIST_MAX;
        e.cosine = any_hit ? 31'(min_cos) : '0;
        exits_due.push_back(e);
        clear_min();
      end
    end
  endtask

  task automatic send_word(input logic signed [31:0] p[3], input logic signed [31:0] d[3],
                           input logic signed [31:0] n[3], input logic signed [31:0] off,
                           input logic [1:0] fn, input logic lst);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    {pos_x, pos_y, pos_z} = {p[0], p[1], p[2]};
    {dir_x, dir_y, dir_z} = {d[0], d[1], d[2]};
    {normal_x, normal_y, normal_z} = {n[0], n[1], n[2]};
    plane_offset = off;
    face_number = fn;
    last_face = lst;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_face();
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] unit_val();
    case ($urandom_range(5))
      0: return 32'sd1073741824;
      1: return -32'sd1073741824;
      2: return '0;
      default: return $signed($urandom_range(2147483647)) - 32'sd1073741824;
    endcase
  endfunction

  function automatic logic signed [31:0] coord_val();
    case ($urandom_range(7))
      0: return $signed($urandom());
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $signed($urandom_range(1 << 22)) - (1 << 21);
    endcase
  endfunction

  task automatic send_ray(input int nfaces, input logic wild);
    logic signed [31:0] p[3], d[3], n[3];
    begin
      for (int i = 0; i < 3; i++) begin
        p[i] = coord_val();
        d[i] = wild ? $signed($urandom()) : unit_val();
      end
      for (int f = 0; f < nfaces; f++) begin
        for (int i = 0; i < 3; i++) n[i] = wild ? $signed($urandom()) : unit_val();
        send_word(p, d, n, coord_val(), wild ? 2'($urandom()) : 2'(f),
                  f == nfaces - 1);
      end
    end
  endtask

  task automatic wait_drain();
    while (exits_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic test_directed();
    logic signed [31:0] p[3], d[3], n[3];
    begin
      p = '{32'sd0, 32'sd0, 32'sd0};
      d = '{32'sd1073741824, 32'sd0, 32'sd0};
      n = '{-32'sd1073741824, 32'sd0, 32'sd0};
      // simple exit at negative distance -2^-14, tie keeps earlier face
      send_word(p, d, n, 32'sd65536, 2'd3, 1'b0);
      send_word(p, d, n, 32'sd65536, 2'd1, 1'b1);
      // no candidate at all
      n = '{32'sd1073741824, 32'sd0, 32'sd0};
      send_word(p, d, n, 32'sd65536, 2'd2, 1'b1);
      // negative distance, origin outside plane
      n = '{-32'sd1073741824, 32'sd0, 32'sd0};
      send_word(p, d, n, -32'sd65536, 2'd0, 1'b0);
      send_word(p, d, n, 32'sd65536, 2'd2, 1'b1);
      // saturated distances at both ends, each in its own ray
      n = '{32'sd0, -32'sd1, 32'sd0};
      d = '{32'sd0, 32'sd1, 32'sd0};
      send_word(p, d, n, 32'h7fffffff, 2'd1, 1'b1);
      send_word(p, d, n, 32'h80000000, 2'd3, 1'b1);
      // cosine beyond -1
      d = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
      n = '{32'h80000000, 32'h80000000, 32'h80000000};
      p = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
      send_word(p, d, n, 32'h80000000, 2'd2, 1'b1);
      p = '{32'h80000000, 32'h7fffffff, 32'h80000000};
      send_word(p, d, n, 32'h7fffffff, 2'd0, 1'b0);
      d = '{-32'sd1, -32'sd1, -32'sd1};
      n = '{-32'sd1, -32'sd1, -32'sd1};
      send_word(p, d, n, 32'sd0, 2'd3, 1'b1);
    end
  endtask

  task automatic test_random_rays();
    while (words_sent < 700) send_ray($urandom_range(1, 6), $urandom_range(9) == 0);
  endtask

  task automatic test_drain_pause();
    wait_drain();
    send_ray(4, 1'b0);
    wait_drain();
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    while (words_sent < 1050) send_ray($urandom_range(1, 4), $urandom_range(7) == 0);
    idle_pct = 20;
  endtask

  always @(negedge clk) out_stall <= (idle_pct != 0) && ($urandom_range(99) < 20);

  always @(posedge clk) begin
    exit_t e;
    if (!rst && out_valid && !out_stall) begin
      if (exits_due.size() == 0) begin
        $display("%0t: unexpected result hit=%0b face=%0d dist=%0d cos=%0d", $time,
                 hit, exit_face, distance, exit_cosine);
        errors++;
      end else begin
        e = exits_due.pop_front();
        rays_checked++;
        if (hit) hits_seen++;
        if (hit !== e.hit) begin
          $display("%0t: hit exp %0b got %0b", $time, e.hit, hit);
          errors++;
        end
        if (exit_face !== e.face) begin
          $display("%0t: exit_face exp %0d got %0d", $time, e.face, exit_face);
          errors++;
        end
        if (distance !== e.dst) begin
          $display("%0t: distance exp %0d got %0d", $time, e.dst, distance);
          errors++;
        end
        if (exit_cosine !== e.cosine) begin
          $display("%0t: exit_cosine exp %0d got %0d", $time, e.cosine, exit_cosine);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    clear_min();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_rays();
    test_drain_pause();
    test_back_to_back();
    wait_drain();
    $display("Sent %0d face words, checked %0d ray results (%0d with a hit).",
             words_sent, rays_checked, hits_seen);
    if (errors == 0 && exits_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/rtef_pkg.sv
design/rtef_mac.sv
design/rtef_div.sv
design/ray_tetrahedron_exit_face.sv
tb/tb_ray_tetrahedron_exit_face.sv
